// ===== sv/lspd_pkg.sv =====
// Package for the lidar scan packet decoder.
// Holds the parser codes, header constants, default parameters and shared types.
// Depends on nothing.
package lspd_pkg;

    // Default sizes, handed to the top level as parameter defaults.
    localparam int DEF_MAX_SAMPLES      = 40;
    localparam int DEF_MAX_CONTROL_DATA = 64;
    localparam int DEF_BUFFER_BYTES     = 256;

    // Position and length counters cover a buffer of up to 1023 bytes.
    localparam int LEN_W = 10;

    localparam logic [LEN_W-1:0] HDR_LEN      = 10'd10;
    localparam logic [LEN_W-1:0] CTRL_HDR_LEN = 10'd7;

    localparam logic [7:0]  SCAN_HDR0 = 8'hAA;
    localparam logic [7:0]  SCAN_HDR1 = 8'h55;
    localparam logic [7:0]  CTRL_HDR0 = 8'hA5;
    localparam logic [7:0]  CTRL_HDR1 = 8'h5A;
    localparam logic [15:0] CS_SEED   = 16'h55AA;

    // One full turn in 1/64 degree.
    localparam logic [17:0] FULL_TURN = 18'd23040;

    localparam logic [5:0] LIMIT_RESET = 6'd40;

    // Dividend and divisor widths of the per-packet angle step division.
    localparam int DIVD_W = 15;
    localparam int DIVS_W = 6;

    typedef enum logic [1:0] {
        MODE_HUNT,
        MODE_SCAN,
        MODE_CTRL
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD,
        ST_OUT
    } state_t;

    // Result of the angle step divider.
    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quo;
        logic [DIVS_W-1:0] rem;
    } div_res_t;

endpackage

// ===== sv/lspd_ram.sv =====
// Generic single-port RAM with a registered read port.
// One access per cycle; a write cycle also reads the old word. Depends on nothing.
module lspd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/lspd_div.sv =====
// Restoring divider for the angle step of one packet, one quotient bit per cycle.
// Depends on lspd_pkg.
module lspd_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [lspd_pkg::DIVD_W-1:0]  dividend,
    input  logic [lspd_pkg::DIVS_W-1:0]  divisor,
    output lspd_pkg::div_res_t           res
);
    import lspd_pkg::*;

    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [DIVS_W-1:0] rem_reg, rem_next;
    logic [DIVS_W-1:0] den_reg, den_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIVS_W:0]   trial;

    // One shift and trial subtract per cycle.
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DIVD_W-1]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = DIVS_W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIVS_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'(DIVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign res.done = done_reg;
    assign res.quo  = quo_reg;
    assign res.rem  = rem_reg;

endmodule

// ===== sv/lidar_scan_packet_decoder.sv =====
// Top level of the lidar scan packet decoder: byte parser, sample buffer and point emitter.
// Depends on lspd_pkg, lspd_ram and lspd_div.
//
// Usage: bytes from the UART enter on the s_axis channel, one item per byte; s_axis_tuser
// high instead resets the parser to header hunting. The parser takes one byte per cycle
// while it is idle. Scan packets (AA 55) are checked against their XOR checksum as bytes
// arrive; control frames (A5 5A) are framed by their length and dropped. On the final byte
// of a good scan packet the block stops accepting bytes and emits one point per sample on
// m_axis, tlast on the final point. Emission runs the angle step division (packets of
// more than one sample) and then, per point, three reads of the sample buffer memory,
// the capture of the last one and the output register, which simply holds the point and
// the parser while the receiver stalls. The user writes the sample count limit through
// cfg_we/cfg_data only while the block is idle; the block itself does not enforce this.
// Reset returns the parser to hunting and the limit to 40; the buffer needs no clearing.
module lidar_scan_packet_decoder #(
    parameter int MAX_SAMPLES      = lspd_pkg::DEF_MAX_SAMPLES,
    parameter int MAX_CONTROL_DATA = lspd_pkg::DEF_MAX_CONTROL_DATA,
    parameter int BUFFER_BYTES     = lspd_pkg::DEF_BUFFER_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [5:0]  cfg_data,       // sample_count_limit
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    input  logic        s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // angle_64ths[15:0], range_mm[29:16], quality[37:30], rate_valid[38],
    // scan_rate_tenths_hz[45:39], zero fill[47:46]
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tuser,   // sync
    output logic        m_axis_tlast    // last
);
    import lspd_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);

    mode_t             mode_reg, mode_next;
    state_t            state_reg, state_next;
    logic [7:0]        fhb_reg, fhb_next;
    logic [LEN_W-1:0]  wp_reg, wp_next;
    logic [LEN_W-1:0]  exp_reg, exp_next;
    logic [15:0]       cs_reg, cs_next;
    logic [1:0]        phase_reg, phase_next;
    logic [7:0]        type_reg, type_next;
    logic [7:0]        n_reg, n_next;
    logic [15:0]       fa_reg, fa_next;
    logic [15:0]       la_reg, la_next;
    logic [15:0]       chk_reg, chk_next;
    logic [5:0]        lim_reg;
    logic [1:0]        k_reg, k_next;
    logic [5:0]        i_reg, i_next;
    logic [AW-1:0]     rp_reg, rp_next;
    logic [7:0]        b0_reg, b0_next;
    logic [7:0]        b1_reg, b1_next;
    logic [7:0]        b2_reg, b2_next;
    logic signed [16:0] qd_reg, qd_next;
    logic [5:0]        rd_reg, rd_next;
    logic signed [17:0] accq_reg, accq_next;
    logic [5:0]        accr_reg, accr_next;

    logic              in_acc, out_acc;
    logic [7:0]        b;
    logic [LEN_W-1:0]  wp_inc;
    logic [7:0]        lim_eff;
    logic [15:0]       clen;
    logic [15:0]       cs_x;
    logic              ram_we;
    logic [AW-1:0]     ram_addr;
    logic [7:0]        ram_rdata;
    logic signed [16:0] d_raw, d_val;
    logic [DIVD_W-1:0] d_mag;
    logic [DIVS_W-1:0] den;
    logic              div_start;
    div_res_t          div_res;
    logic [6:0]        r_sum;
    logic signed [17:0] a_raw, a_fin;
    logic              start_pkt;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign b       = s_axis_tdata;
    assign wp_inc  = wp_reg + LEN_W'(1);
    assign lim_eff = ({2'b0, lim_reg} > 8'(MAX_SAMPLES)) ? 8'(MAX_SAMPLES) : {2'b0, lim_reg};
    assign clen    = {n_reg, type_reg};
    assign den     = DIVS_W'(n_reg - 8'd1);
    assign start_pkt = type_reg[0];

    // Angle span of the packet, wrapped once into the turn.
    assign d_raw = $signed({2'b0, la_reg[15:1]}) - $signed({2'b0, fa_reg[15:1]});
    assign d_val = (d_raw < 0) ? d_raw + $signed(FULL_TURN[16:0]) : d_raw;
    assign d_mag = (d_val < 0) ? DIVD_W'(-d_val) : DIVD_W'(d_val);

    // Parser, emitter sequencing and buffer access.
    always_comb
    begin
        mode_next  = mode_reg;
        state_next = state_reg;
        fhb_next   = fhb_reg;
        wp_next    = wp_reg;
        exp_next   = exp_reg;
        cs_next    = cs_reg;
        phase_next = phase_reg;
        type_next  = type_reg;
        n_next     = n_reg;
        fa_next    = fa_reg;
        la_next    = la_reg;
        chk_next   = chk_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        rp_next    = rp_reg;
        b0_next    = b0_reg;
        b1_next    = b1_reg;
        b2_next    = b2_reg;
        qd_next    = qd_reg;
        rd_next    = rd_reg;
        accq_next  = accq_reg;
        accr_next  = accr_reg;
        ram_we     = 1'b0;
        ram_addr   = wp_reg[AW-1:0];
        div_start  = 1'b0;
        cs_x       = cs_reg;
        r_sum      = {1'b0, accr_reg} + {1'b0, rd_reg};

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (s_axis_tuser)
                    begin
                        mode_next = MODE_HUNT;
                        fhb_next  = '0;
                        wp_next   = '0;
                        exp_next  = '0;
                    end
                    else if (mode_reg == MODE_HUNT)
                    begin
                        // Header search.
                        if (fhb_reg == 8'h00)
                        begin
                            if (b == SCAN_HDR0 || b == CTRL_HDR0)
                            begin
                                fhb_next = b;
                            end
                        end
                        else if (fhb_reg == SCAN_HDR0 && b == SCAN_HDR1)
                        begin
                            mode_next  = MODE_SCAN;
                            wp_next    = LEN_W'(2);
                            exp_next   = HDR_LEN;
                            cs_next    = CS_SEED;
                            phase_next = '0;
                        end
                        else if (fhb_reg != SCAN_HDR0 && b == CTRL_HDR1)
                        begin
                            mode_next = MODE_CTRL;
                            wp_next   = LEN_W'(2);
                            exp_next  = CTRL_HDR_LEN;
                        end
                        else if (b == SCAN_HDR0 || b == CTRL_HDR0)
                        begin
                            fhb_next = b;
                        end
                        else
                        begin
                            fhb_next = '0;
                        end
                    end
                    else if (wp_reg >= LEN_W'(BUFFER_BYTES))
                    begin
                        // Buffer overflow drops the byte and the packet.
                        mode_next = MODE_HUNT;
                        fhb_next  = '0;
                        wp_next   = '0;
                        exp_next  = '0;
                    end
                    else
                    begin
                        wp_next = wp_inc;
                        // Header fields are kept in registers, samples go to memory.
                        case (wp_reg)
                            LEN_W'(2): type_next = b;
                            LEN_W'(3): n_next = b;
                            LEN_W'(4): fa_next[7:0] = b;
                            LEN_W'(5): fa_next[15:8] = b;
                            LEN_W'(6): la_next[7:0] = b;
                            LEN_W'(7): la_next[15:8] = b;
                            LEN_W'(8): chk_next[7:0] = b;
                            LEN_W'(9): chk_next[15:8] = b;
                            default: ram_we = 1'b1;
                        endcase
                        if (mode_reg == MODE_SCAN)
                        begin
                            // Running checksum over header words and sample words.
                            if (wp_reg >= HDR_LEN)
                            begin
                                if (phase_reg == 2'd2)
                                begin
                                    cs_x = cs_reg ^ {b, 8'h00};
                                    phase_next = 2'd0;
                                end
                                else
                                begin
                                    cs_x = cs_reg ^ {8'h00, b};
                                    phase_next = phase_reg + 2'd1;
                                end
                            end
                            else if (wp_reg >= LEN_W'(2) && wp_reg <= LEN_W'(7))
                            begin
                                cs_x = wp_reg[0] ? cs_reg ^ {b, 8'h00} : cs_reg ^ {8'h00, b};
                            end
                            cs_next = cs_x;
                            if (wp_reg == LEN_W'(3))
                            begin
                                if (b == 8'h00 || b > lim_eff)
                                begin
                                    mode_next = MODE_HUNT;
                                    fhb_next  = '0;
                                    wp_next   = '0;
                                    exp_next  = '0;
                                end
                                else
                                begin
                                    exp_next = HDR_LEN + LEN_W'(3) * LEN_W'(b);
                                end
                            end
                            else if (wp_inc >= exp_reg && wp_inc >= HDR_LEN)
                            begin
                                // Packet complete: clear the parser, emit if the sum holds.
                                mode_next = MODE_HUNT;
                                fhb_next  = '0;
                                wp_next   = '0;
                                exp_next  = '0;
                                if (cs_x == chk_reg)
                                begin
                                    i_next    = '0;
                                    k_next    = '0;
                                    rp_next   = AW'(HDR_LEN);
                                    accq_next = '0;
                                    accr_next = '0;
                                    qd_next   = '0;
                                    rd_next   = '0;
                                    if (n_reg > 8'd1)
                                    begin
                                        div_start  = 1'b1;
                                        state_next = ST_DIV;
                                    end
                                    else
                                    begin
                                        state_next = ST_RD;
                                    end
                                end
                            end
                        end
                        else
                        begin
                            // Control frame: length check, then count bytes off.
                            if (wp_reg == LEN_W'(6))
                            begin
                                if (clen > 16'(MAX_CONTROL_DATA))
                                begin
                                    mode_next = MODE_HUNT;
                                    fhb_next  = '0;
                                    wp_next   = '0;
                                    exp_next  = '0;
                                end
                                else if (clen == 16'h0000)
                                begin
                                    mode_next = MODE_HUNT;
                                    fhb_next  = '0;
                                    wp_next   = '0;
                                    exp_next  = '0;
                                end
                                else
                                begin
                                    exp_next = CTRL_HDR_LEN + LEN_W'(clen);
                                end
                            end
                            else if (wp_inc >= exp_reg && wp_inc >= CTRL_HDR_LEN)
                            begin
                                mode_next = MODE_HUNT;
                                fhb_next  = '0;
                                wp_next   = '0;
                                exp_next  = '0;
                            end
                        end
                    end
                end
            end

            ST_DIV:
            begin
                // Floor division of the span by n-1, as quotient and remainder.
                if (div_res.done)
                begin
                    if (d_val < 0)
                    begin
                        if (div_res.rem != '0)
                        begin
                            qd_next = -$signed({2'b0, div_res.quo}) - 17'sd1;
                            rd_next = den - div_res.rem;
                        end
                        else
                        begin
                            qd_next = -$signed({2'b0, div_res.quo});
                            rd_next = '0;
                        end
                    end
                    else
                    begin
                        qd_next = $signed({2'b0, div_res.quo});
                        rd_next = div_res.rem;
                    end
                    state_next = ST_RD;
                end
            end

            ST_RD:
            begin
                // Three buffer reads, each captured in the cycle after its address.
                ram_addr = rp_reg;
                if (k_reg != 2'd3)
                begin
                    rp_next = rp_reg + AW'(1);
                end
                case (k_reg)
                    2'd1: b0_next = ram_rdata;
                    2'd2: b1_next = ram_rdata;
                    2'd3: b2_next = ram_rdata;
                    default: ;
                endcase
                k_next = k_reg + 2'd1;
                if (k_reg == 2'd3)
                begin
                    state_next = ST_OUT;
                end
            end

            ST_OUT:
            begin
                // Hold the point until taken, then step the angle accumulator.
                ram_addr = rp_reg;
                if (out_acc)
                begin
                    if (m_axis_tlast)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        i_next = i_reg + 6'd1;
                        k_next = '0;
                        if (r_sum >= {1'b0, den})
                        begin
                            accr_next = 6'(r_sum - {1'b0, den});
                            accq_next = accq_reg + 18'(qd_reg) + 18'sd1;
                        end
                        else
                        begin
                            accr_next = r_sum[5:0];
                            accq_next = accq_reg + 18'(qd_reg);
                        end
                        state_next = ST_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_HUNT;
            state_reg <= ST_IDLE;
            fhb_reg   <= '0;
            wp_reg    <= '0;
            exp_reg   <= '0;
            k_reg     <= '0;
            i_reg     <= '0;
            lim_reg   <= LIMIT_RESET;
        end
        else
        begin
            mode_reg  <= mode_next;
            state_reg <= state_next;
            fhb_reg   <= fhb_next;
            wp_reg    <= wp_next;
            exp_reg   <= exp_next;
            k_reg     <= k_next;
            i_reg     <= i_next;
            if (cfg_we)
            begin
                lim_reg <= cfg_data;
            end
        end
    end

    // Packet and point payload registers.
    always_ff @(posedge clk)
    begin
        cs_reg    <= cs_next;
        phase_reg <= phase_next;
        type_reg  <= type_next;
        n_reg     <= n_next;
        fa_reg    <= fa_next;
        la_reg    <= la_next;
        chk_reg   <= chk_next;
        rp_reg    <= rp_next;
        b0_reg    <= b0_next;
        b1_reg    <= b1_next;
        b2_reg    <= b2_next;
        qd_reg    <= qd_next;
        rd_reg    <= rd_next;
        accq_reg  <= accq_next;
        accr_reg  <= accr_next;
    end

    lspd_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (b),
        .rdata (ram_rdata)
    );

    lspd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (d_mag),
        .divisor  (den),
        .res      (div_res)
    );

    // Point angle with one wrap at the full turn.
    assign a_raw = $signed({3'b0, fa_reg[15:1]}) + accq_reg;
    assign a_fin = (a_raw >= $signed(FULL_TURN)) ? a_raw - $signed(FULL_TURN) : a_raw;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = {2'b00,
                            start_pkt ? type_reg[7:1] : 7'd0,
                            start_pkt,
                            b1_reg[1:0], b0_reg[7:2],
                            b2_reg, b1_reg[7:2],
                            a_fin[15:0]};
    assign m_axis_tuser  = start_pkt && (i_reg == 6'd0);
    assign m_axis_tlast  = ({2'b00, i_reg} == n_reg - 8'd1);

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the lidar scan packet decoder: byte stream in, points out.
// A scoreboard class predicts each point from the accepted bytes and checks the outputs.
// Depends on lspd_pkg and lidar_scan_packet_decoder.
`timescale 1ns / 1ps

typedef struct packed {
    logic [15:0] angle;
    logic [13:0] range_mm;
    logic [7:0]  qual;
    logic        sync;
    logic        rate_ok;
    logic [6:0]  rate;
    logic        last;
} point_t;

class point_scoreboard;
    lspd_pkg::mode_t mode;
    logic [7:0]  hdr_byte;
    int          wpos;
    int          need_len;
    logic [7:0]  pkt [256];
    int          count_limit;
    point_t      pending_points[$];
    int          errors;

    function void clear_parser();
        mode = lspd_pkg::MODE_HUNT;
        hdr_byte = '0;
        wpos = 0;
        need_len = 0;
    endfunction

    function void reset_all();
        count_limit = 40;
        errors = 0;
        clear_parser();
    endfunction

    function int le16(int at);
        return pkt[at] | (pkt[at+1] << 8);
    endfunction

    // Verify checksum and queue one point per sample.
    function void emit_points();
        int n;
        int cs;
        int s;
        int e;
        int d;
        int a;
        int num;
        int q;
        bit start;
        point_t p;
        n = pkt[3];
        start = pkt[2][0];
        cs = 16'h55AA ^ le16(4) ^ le16(2) ^ le16(6);
        for (int i = 0; i < n; i++)
            cs = cs ^ pkt[10+3*i] ^ le16(11+3*i);
        if ((cs & 16'hFFFF) != le16(8))
            return;
        s = le16(4) >> 1;
        e = le16(6) >> 1;
        d = e - s;
        if (d < 0)
            d += 23040;
        for (int i = 0; i < n; i++)
        begin
            a = s;
            if (n > 1)
            begin
                // Floor division, also for a negative span.
                num = d * i;
                q = num / (n - 1);
                if (num < 0 && (num % (n - 1)) != 0)
                    q = q - 1;
                a = s + q;
            end
            if (a >= 23040)
                a -= 23040;
            p.angle = a[15:0];
            p.range_mm = {pkt[12+3*i], pkt[11+3*i][7:2]};
            p.qual = {pkt[11+3*i][1:0], pkt[10+3*i][7:2]};
            p.sync = start && (i == 0);
            p.rate_ok = start;
            p.rate = start ? pkt[2][7:1] : 7'd0;
            p.last = (i == n - 1);
            pending_points.push_back(p);
        end
    endfunction

    // Note one accepted input item.
    function void note_byte(bit op, logic [7:0] b);
        int lim;
        int len;
        if (op)
        begin
            clear_parser();
            return;
        end
        if (mode == lspd_pkg::MODE_HUNT)
        begin
            if (hdr_byte == 0)
            begin
                if (b == 8'hAA || b == 8'hA5)
                    hdr_byte = b;
            end
            else if (hdr_byte == 8'hAA && b == 8'h55)
            begin
                pkt[0] = 8'hAA;
                pkt[1] = 8'h55;
                wpos = 2;
                need_len = 10;
                mode = lspd_pkg::MODE_SCAN;
            end
            else if (hdr_byte != 8'hAA && b == 8'h5A)
            begin
                pkt[0] = 8'hA5;
                pkt[1] = 8'h5A;
                wpos = 2;
                need_len = 7;
                mode = lspd_pkg::MODE_CTRL;
            end
            else if (b == 8'hAA || b == 8'hA5)
                hdr_byte = b;
            else
                hdr_byte = '0;
            return;
        end
        if (wpos >= 256)
        begin
            clear_parser();
            return;
        end
        pkt[wpos] = b;
        wpos++;
        if (mode == lspd_pkg::MODE_SCAN)
        begin
            if (wpos == 4)
            begin
                lim = (count_limit > 40) ? 40 : count_limit;
                if (pkt[3] == 0 || pkt[3] > lim)
                begin
                    clear_parser();
                    return;
                end
                need_len = 10 + 3 * pkt[3];
            end
            if (wpos >= need_len && wpos >= 10)
            begin
                emit_points();
                clear_parser();
            end
            return;
        end
        if (wpos == 7)
        begin
            len = le16(2);
            if (len > 64)
            begin
                clear_parser();
                return;
            end
            need_len = 7 + len;
        end
        if (wpos >= need_len && wpos >= 7)
            clear_parser();
    endfunction

    // Compare one output point with the oldest expected one.
    function void check_point(point_t got);
        point_t want;
        if (pending_points.size() == 0)
        begin
            $display("%0t: unexpected point %h", $time, got);
            errors++;
            return;
        end
        want = pending_points.pop_front();
        if (want.angle !== got.angle)
            $display("%0t: angle expected %0d actual %0d", $time, want.angle, got.angle);
        if (want.range_mm !== got.range_mm)
            $display("%0t: distance expected %0d actual %0d", $time, want.range_mm,
                got.range_mm);
        if (want.qual !== got.qual)
            $display("%0t: quality expected %0d actual %0d", $time, want.qual, got.qual);
        if (want.sync !== got.sync)
            $display("%0t: sync expected %0d actual %0d", $time, want.sync, got.sync);
        if (want.rate_ok !== got.rate_ok)
            $display("%0t: rate_valid expected %0d actual %0d", $time, want.rate_ok,
                got.rate_ok);
        if (want.rate !== got.rate)
            $display("%0t: rate expected %0d actual %0d", $time, want.rate, got.rate);
        if (want.last !== got.last)
            $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
        if (want !== got)
            errors++;
    endfunction
endclass

module tb_top;
    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [5:0]  cfg_data = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 0;
    logic        s_axis_tuser = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    point_scoreboard sb;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  quiet_cycles = 0;
    int  items_sent = 0;
    byte unsigned stream[$];
    bit  ops[$];

    lidar_scan_packet_decoder DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always #6 clk = ~clk;

    // Output side: random stall, check every accepted point.
    always @(posedge clk)
    begin
        point_t got;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.angle = m_axis_tdata[15:0];
                got.range_mm = m_axis_tdata[29:16];
                got.qual = m_axis_tdata[37:30];
                got.rate_ok = m_axis_tdata[38];
                got.rate = m_axis_tdata[45:39];
                got.sync = m_axis_tuser;
                got.last = m_axis_tlast;
                sb.check_point(got);
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles with no accepted item on either side.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Send one item and wait until it is accepted; send_idle_pct may idle before it.
    task automatic send_item(bit op, logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= b;
        s_axis_tuser <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_byte(op, b);
        items_sent++;
    endtask

    task automatic flush_queue();
        while (stream.size() > 0)
            send_item(ops.pop_front(), stream.pop_front());
    endtask

    task automatic push_bytes(byte unsigned b);
        stream.push_back(b);
        ops.push_back(1'b0);
    endtask

    // Build a scan packet; a bad checksum when corrupt is set.
    task automatic make_scan(int n, int first_a, int last_a, bit start, bit corrupt);
        byte unsigned smp[$];
        int cs;
        byte unsigned type_b;
        type_b = {7'($urandom_range(127)), start};
        for (int i = 0; i < 3 * n; i++)
            smp.push_back(8'($urandom_range(255)));
        cs = 16'h55AA ^ first_a ^ last_a ^ (type_b | (n << 8));
        for (int i = 0; i < n; i++)
            cs = cs ^ smp[3*i] ^ (smp[3*i+1] | (smp[3*i+2] << 8));
        if (corrupt)
            cs = cs ^ (1 << $urandom_range(15));
        push_bytes(8'hAA);
        push_bytes(8'h55);
        push_bytes(type_b);
        push_bytes(8'(n));
        push_bytes(8'(first_a));
        push_bytes(8'(first_a >> 8));
        push_bytes(8'(last_a));
        push_bytes(8'(last_a >> 8));
        push_bytes(8'(cs));
        push_bytes(8'(cs >> 8));
        foreach (smp[i])
            push_bytes(smp[i]);
    endtask

    task automatic make_ctrl(int len);
        push_bytes(8'hA5);
        push_bytes(8'h5A);
        push_bytes(8'(len));
        push_bytes(8'(len >> 8));
        for (int i = 0; i < 3 + len; i++)
            push_bytes(8'($urandom_range(255)));
    endtask

    // Wait for all points, then for the block to settle before a register write.
    task automatic write_limit(int value);
        s_axis_tvalid <= 0;
        while (sb.pending_points.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        cfg_we <= 1;
        cfg_data <= 6'(value);
        sb.count_limit = value;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    task automatic random_phase(int items);
        int k;
        int target;
        int cut;
        target = items_sent + items;
        while (items_sent < target)
        begin
            k = $urandom_range(99);
            if (k < 60)
                make_scan(($urandom_range(3) == 0) ? $urandom_range(1, 40) :
                    $urandom_range(1, 6), $urandom_range(65535), $urandom_range(65535),
                    1'($urandom_range(1)), $urandom_range(9) == 0);
            else if (k < 70)
                make_ctrl($urandom_range(0, 8));
            else if (k < 85)
                push_bytes(8'($urandom_range(255)));
            else if (k < 90)
            begin
                stream.push_back(8'($urandom_range(255)));
                ops.push_back(1'b1);
            end
            else
            begin
                make_scan($urandom_range(1, 5), $urandom_range(65535),
                    $urandom_range(65535), 1'b1, 1'b0);
                cut = $urandom_range(1, 8);
                repeat (cut)
                begin
                    void'(stream.pop_back());
                    void'(ops.pop_back());
                end
            end
            flush_queue();
        end
    endtask

    initial
    begin
        sb = new();
        sb.reset_all();
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extremes, parser reset, bad count, long control frame, header restarts.
        make_scan(1, 0, 0, 1'b1, 1'b0);
        make_scan(3, 46079, 1, 1'b0, 1'b0);
        push_bytes(8'hAA); push_bytes(8'hAA); push_bytes(8'hA5); push_bytes(8'h13);
        make_scan(2, 46078, 2, 1'b1, 1'b1);
        stream.push_back(8'hFF); ops.push_back(1'b1);
        make_ctrl(2);
        // Control frame longer than allowed: dropped once its header is in.
        push_bytes(8'hA5); push_bytes(8'h5A); push_bytes(8'd65); push_bytes(8'd0);
        push_bytes(8'h00); push_bytes(8'h00); push_bytes(8'h00);
        push_bytes(8'hAA); push_bytes(8'h55); push_bytes(8'h01); push_bytes(8'd0);
        flush_queue();
        write_limit(0);
        make_scan(2, 5, 7, 1'b1, 1'b0);
        flush_queue();
        write_limit(63);
        push_bytes(8'hAA); push_bytes(8'h55); push_bytes(8'h01); push_bytes(8'd41);
        make_scan(40, 65535, 0, 1'b1, 1'b0);
        flush_queue();
        write_limit(1);
        push_bytes(8'hAA); push_bytes(8'h55); push_bytes(8'h01); push_bytes(8'd2);
        make_scan(1, 5, 7, 1'b1, 1'b0);
        flush_queue();
        write_limit(40);

        // Random phases with several idling patterns.
        random_phase(15);
        send_idle_pct = 77;
        random_phase(15);
        send_idle_pct = 0;
        recv_stall_pct = 77;
        random_phase(15);
        write_limit($urandom_range(1, 39));
        send_idle_pct = 30;
        recv_stall_pct = 30;
        random_phase(20);

        s_axis_tvalid <= 0;
        while (sb.pending_points.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule

// ===== sim.f =====
sv/lspd_pkg.sv
sv/lspd_ram.sv
sv/lspd_div.sv
sv/lidar_scan_packet_decoder.sv
tb/tb_top.sv
